@@ rtl/core/svm_compare_generator_defines.svh @@
// ----------------------------------------------------------------------------
// svm compare generator assertion macros
// shared property wrappers clocked on clk and gated by arst_n
// ----------------------------------------------------------------------------
`ifndef SVM_COMPARE_GENERATOR_DEFINES_SVH
`define SVM_COMPARE_GENERATOR_DEFINES_SVH

// condition implies consequence in the same cycle
`define SVMCG_ASSERT_SAME(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("svmcg assertion failed");

// condition implies consequence in the next cycle
`define SVMCG_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("svmcg assertion failed");

`endif

@@ rtl/core/svmcg_pkg.sv @@
// ----------------------------------------------------------------------------
// svmcg_pkg
// shared constants, phase codes and the sector to phase map
// ----------------------------------------------------------------------------
package svmcg_pkg;

	// pi / 3 in Q2.30 and 1.0 in Q2.30
	localparam longint unsigned PI_THIRD_Q30 = 64'd1124419809;
	localparam logic [30:0]     ONE_Q30      = 31'h4000_0000;
	// 1.0 in Q1.15
	localparam logic [15:0]     MAG_ONE      = 16'd32768;

	localparam int SINE_W = 15;
	localparam int DUTY_W = 30;

	// register index as decoded from paddr[2]
	localparam logic REG_MAGNITUDE = 1'b0;
	localparam logic REG_PERIOD    = 1'b1;

	typedef enum logic [1:0] {
		PHASE_A = 2'd0,
		PHASE_B = 2'd1,
		PHASE_C = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t ph_first;
		phase_t ph_second;
		phase_t ph_third;
	} phases_t;

	function automatic phases_t phase_map(input logic [2:0] sector);
		phases_t p;
		case (sector)
			3'd0: p = '{PHASE_A, PHASE_B, PHASE_C};
			3'd1: p = '{PHASE_B, PHASE_A, PHASE_C};
			3'd2: p = '{PHASE_B, PHASE_C, PHASE_A};
			3'd3: p = '{PHASE_C, PHASE_B, PHASE_A};
			3'd4: p = '{PHASE_C, PHASE_A, PHASE_B};
			default: p = '{PHASE_A, PHASE_C, PHASE_B};
		endcase
		return p;
	endfunction

endpackage

@@ rtl/core/svm_compare_generator.sv @@
// ----------------------------------------------------------------------------
// svm_compare_generator
// center-aligned space-vector compare generator, six-stage pipeline
// ----------------------------------------------------------------------------
// Usage: each input beat on s_t* carries an electrical angle in the low
// ANGLE_BITS bits of s_tdata (2^ANGLE_BITS is one turn). For every beat one
// output beat on m_t* carries the sector, three cumulative compare counts
// and the phase toggled by each compare channel.
// The input handshake loads the first stage and each beat moves on through the
// six pipeline registers to m_tvalid; one beat is taken every cycle while the
// receiver keeps up, each register loading when it is empty or the stage
// after it moves.
// When the receiver stalls, the output register holds its beat and empty
// stages upstream keep filling, so s_tready drops only once all six are full.
// magnitude and period_counts are written over the APB port (byte addresses
// 0 and 4, paddr[2] selects) and are read by the stages directly, so they
// should be changed only while the pipeline is empty.
// Reset clears all valid bits, sets magnitude to 0 and period_counts to
// 65535.
// ----------------------------------------------------------------------------
`include "svm_compare_generator_defines.svh"

module svm_compare_generator
	import svmcg_pkg::*;
#(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// angle [ANGLE_BITS-1:0], zero fill above
	input  logic [((ANGLE_BITS+7)/8)*8-1:0]     s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sector [2:0], cmp_first [18:3], cmp_second [34:19], cmp_third [50:35],
	// phase_first [52:51], phase_second [54:53], phase_third [56:55], zero fill
	output logic [63:0]                         m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int SCL_W  = ANGLE_BITS + 3;
	localparam int PIDX_W = ANGLE_BITS + IDX_W + 1;

	// ------------------------------------------------------------------ config
	logic [15:0] magnitude_q;
	logic [15:0] period_q;
	logic [15:0] mag_sat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnitude_q <= '0;
			period_q    <= 16'hFFFF;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_MAGNITUDE: magnitude_q <= pwdata[15:0];
				REG_PERIOD:    period_q    <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	assign prdata  = (paddr[2] == REG_PERIOD) ? {16'd0, period_q} : {16'd0, magnitude_q};
	assign mag_sat = (magnitude_q > MAG_ONE) ? MAG_ONE : magnitude_q;

	// ---------------------------------------------------------------- control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !vld_s6 || m_tready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign s_tready = en1;
	assign m_tvalid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	// ------------------------------------------------ stage 1: sector, index
	logic [ANGLE_BITS-1:0] angle;
	logic [SCL_W-1:0]      scaled;
	logic [PIDX_W-1:0]     idx_prod;
	logic [2:0]            sector_s1;
	logic [IDX_W-1:0]      idx_s1;

	assign angle    = s_tdata[ANGLE_BITS-1:0];
	assign scaled   = SCL_W'(angle) * SCL_W'(6);
	assign idx_prod = PIDX_W'(scaled[ANGLE_BITS-1:0]) * PIDX_W'(SINE_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (en1) begin
			sector_s1 <= scaled[SCL_W-1:ANGLE_BITS];
			idx_s1    <= idx_prod[ANGLE_BITS+IDX_W-1:ANGLE_BITS];
		end
	end

	// ------------------------------------------------- stage 2: table lookup
	logic [2:0]        sector_s2;
	logic [SINE_W-1:0] word_a_s2;
	logic [SINE_W-1:0] word_b_s2;

	svmcg_sine_rom #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk       (clk),
		.en        (en2),
		.idx       (idx_s1),
		.odd       (sector_s1[0]),
		.word_a_s2 (word_a_s2),
		.word_b_s2 (word_b_s2)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			sector_s2 <= sector_s1;
		end
	end

	// -------------------------------------------- stage 3: scale by magnitude
	logic [2:0]        sector_s3;
	logic [DUTY_W-1:0] d1_s3;
	logic [DUTY_W-1:0] d2_s3;
	logic [30:0]       prod_a;
	logic [30:0]       prod_b;

	assign prod_a = 31'(mag_sat) * 31'(word_a_s2);
	assign prod_b = 31'(mag_sat) * 31'(word_b_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			sector_s3 <= sector_s2;
			d1_s3     <= prod_a[DUTY_W-1:0];
			d2_s3     <= prod_b[DUTY_W-1:0];
		end
	end

	// ------------------------------------------------- stage 4: zero vector
	logic [2:0]        sector_s4;
	logic [DUTY_W-1:0] d1_s4;
	logic [DUTY_W-1:0] d2_s4;
	logic [30:0]       z_s4;
	logic [30:0]       dsum;

	assign dsum = 31'(d1_s3) + 31'(d2_s3);

	always_ff @(posedge clk) begin
		if (en4) begin
			sector_s4 <= sector_s3;
			d1_s4     <= d1_s3;
			d2_s4     <= d2_s3;
			z_s4      <= (dsum >= ONE_Q30) ? 31'd0 : ONE_Q30 - dsum;
		end
	end

	// ----------------------------------------------- stage 5: period scaling
	logic [2:0]  sector_s5;
	logic [15:0] t0_s5;
	logic [15:0] t1_s5;
	logic [15:0] t2_s5;
	logic [46:0] pz;
	logic [45:0] pd1;
	logic [45:0] pd2;

	assign pz  = 47'(period_q) * 47'(z_s4);
	assign pd1 = 46'(period_q) * 46'(d1_s4);
	assign pd2 = 46'(period_q) * 46'(d2_s4);

	always_ff @(posedge clk) begin
		if (en5) begin
			sector_s5 <= sector_s4;
			t0_s5     <= pz[46:31];
			t1_s5     <= pd1[45:30];
			t2_s5     <= pd2[45:30];
		end
	end

	// --------------------------------------- stage 6: accumulate and clamp
	logic [17:0] c1;
	logic [17:0] c2;
	logic [17:0] c3;
	logic [17:0] p_ext;
	logic [2:0]  sector_s6;
	logic [15:0] cmp1_s6;
	logic [15:0] cmp2_s6;
	logic [15:0] cmp3_s6;
	phases_t     phases_s6;

	assign p_ext = 18'(period_q);
	assign c1    = 18'(t0_s5);
	assign c2    = c1 + 18'(t1_s5);
	assign c3    = c2 + 18'(t2_s5);

	always_ff @(posedge clk) begin
		if (en6) begin
			sector_s6 <= sector_s5;
			cmp1_s6   <= (c1 > p_ext) ? period_q : c1[15:0];
			cmp2_s6   <= (c2 > p_ext) ? period_q : c2[15:0];
			cmp3_s6   <= (c3 > p_ext) ? period_q : c3[15:0];
			phases_s6 <= phase_map(sector_s5);
		end
	end

	assign m_tdata = {7'd0, phases_s6.ph_third, phases_s6.ph_second, phases_s6.ph_first,
		cmp3_s6, cmp2_s6, cmp1_s6, sector_s6};

	// ------------------------------------------------------------ assertions
	`SVMCG_ASSERT_SAME(a_zero_time, vld_s4,
		(z_s4 == 31'd0) || ((z_s4 + 31'(d1_s4) + 31'(d2_s4)) == ONE_Q30))
	`SVMCG_ASSERT_SAME(a_cmp_order, vld_s6, (cmp1_s6 <= cmp2_s6) && (cmp2_s6 <= cmp3_s6))
	`SVMCG_ASSERT_SAME(a_phase_perm, vld_s6,
		(phases_s6.ph_first != phases_s6.ph_second) &&
		(phases_s6.ph_first != phases_s6.ph_third) &&
		(phases_s6.ph_second != phases_s6.ph_third))
	`SVMCG_ASSERT_NEXT(a_hold_full, vld_s6 && !m_tready, vld_s6)

endmodule

@@ rtl/core/svmcg_sine_rom.sv @@
// ----------------------------------------------------------------------------
// svmcg_sine_rom
// sine table over 0..60 degrees with two registered reads, ordered by sector
// ----------------------------------------------------------------------------
module svmcg_sine_rom
	import svmcg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] idx,
	input  logic                                odd,
	output logic [SINE_W-1:0]                   word_a_s2,
	output logic [SINE_W-1:0]                   word_b_s2
);

	localparam int K_W   = $clog2(SINE_TABLE_DEPTH + 1);

	// five-term taylor series in Q2.30, rounded to Q0.15
	function automatic logic [SINE_W-1:0] sine_word(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x    = (PI_THIRD_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		return SINE_W'((sum + 64'sd16384) >>> 15);
	endfunction

	logic [SINE_W-1:0] rom [0:SINE_TABLE_DEPTH];
	logic [K_W-1:0]    idx_lo;
	logic [K_W-1:0]    idx_hi;

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign rom[g] = sine_word(g);
	end

	assign idx_lo = K_W'(idx);
	assign idx_hi = K_W'(SINE_TABLE_DEPTH) - idx_lo;

	// even sectors lead with the far word, odd sectors swap
	always_ff @(posedge clk) begin
		if (en) begin
			word_a_s2 <= odd ? rom[idx_lo] : rom[idx_hi];
			word_b_s2 <= odd ? rom[idx_hi] : rom[idx_lo];
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm compare generator testbench
// streams angles through the compare generator under several magnitude and
// period settings, predicts sector, compare counts and phases for every beat
// and checks each output beat in order, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb;
	import svmcg_pkg::*;

	localparam int          ROM_DEPTH   = 256;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          LATENCY     = 6;
	localparam logic [2:0]  ADDR_MAG    = {REG_MAGNITUDE, 2'b00};
	localparam logic [2:0]  ADDR_PERIOD = {REG_PERIOD, 2'b00};

	typedef struct packed {
		logic [2:0]  sector;
		logic [15:0] cmp_first;
		logic [15:0] cmp_second;
		logic [15:0] cmp_third;
		phase_t      ph_first;
		phase_t      ph_second;
		phase_t      ph_third;
	} cmp_beat_t;

	// predicts the compare beat of each accepted angle and checks output beats
	class compare_book;
		longint unsigned sine_q15 [0:ROM_DEPTH];
		phase_t          ph_tab [6][3];
		logic [15:0]     magnitude;
		logic [15:0]     period;
		cmp_beat_t       pending [$];
		int              errors;
		int              angles_seen;
		int              beats_seen;

		function new();
			longint unsigned x, x2, term;
			longint          acc;
			for (int k = 0; k <= ROM_DEPTH; k++) begin
				x = (PI_THIRD_Q30 * k) / ROM_DEPTH;
				x2 = (x * x) >> 30;
				term = x;
				acc = longint'(x);
				for (int n = 1; n <= 4; n++) begin
					term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						acc = acc - longint'(term);
					end else begin
						acc = acc + longint'(term);
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				sine_q15[k] = (longint'(acc) + 16384) >> 15;
			end
			ph_tab = '{'{PHASE_A, PHASE_B, PHASE_C}, '{PHASE_B, PHASE_A, PHASE_C},
				'{PHASE_B, PHASE_C, PHASE_A}, '{PHASE_C, PHASE_B, PHASE_A},
				'{PHASE_C, PHASE_A, PHASE_B}, '{PHASE_A, PHASE_C, PHASE_B}};
			magnitude = 16'd0;
			period = 16'd65535;
			errors = 0;
			angles_seen = 0;
			beats_seen = 0;
		endfunction

		function void note_angle(logic [15:0] angle);
			longint unsigned scaled, sec, frac, idx, m, s_lo, s_hi, d1, d2, z, p;
			longint unsigned c1, c2, c3;
			cmp_beat_t       e;
			scaled = longint'(angle) * 6;
			sec = scaled >> 16;
			frac = scaled - (sec << 16);
			idx = (frac * ROM_DEPTH) >> 16;
			m = (magnitude > MAG_ONE) ? MAG_ONE : magnitude;
			s_lo = sine_q15[idx];
			s_hi = sine_q15[ROM_DEPTH - idx];
			if (sec > 5) begin
				sec = 5;
			end
			// odd sectors run the two active vectors in the other order
			if (sec % 2 == 1) begin
				d1 = m * s_lo;
				d2 = m * s_hi;
			end else begin
				d1 = m * s_hi;
				d2 = m * s_lo;
			end
			z = (d1 + d2 >= ONE_Q30) ? 0 : longint'(ONE_Q30) - d1 - d2;
			p = period;
			c1 = (p * z) >> 31;
			c2 = c1 + ((p * d1) >> 30);
			c3 = c2 + ((p * d2) >> 30);
			// sine rounding can push the sum past one period
			if (c1 > p) c1 = p;
			if (c2 > p) c2 = p;
			if (c3 > p) c3 = p;
			e.sector = sec[2:0];
			e.cmp_first = c1[15:0];
			e.cmp_second = c2[15:0];
			e.cmp_third = c3[15:0];
			e.ph_first = ph_tab[sec][0];
			e.ph_second = ph_tab[sec][1];
			e.ph_third = ph_tab[sec][2];
			pending.push_back(e);
			angles_seen++;
		endfunction

		function void field_diff(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch beat %0d %s: expected %0d got %0d", beats_seen, name,
						exp_v, act_v);
				end
			end
		endfunction

		function void check_beat(logic [63:0] data);
			cmp_beat_t e;
			beats_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected output beat %0d: %h", beats_seen, data);
				end
				return;
			end
			e = pending.pop_front();
			field_diff("sector", e.sector, data[2:0]);
			field_diff("cmp_first", e.cmp_first, data[18:3]);
			field_diff("cmp_second", e.cmp_second, data[34:19]);
			field_diff("cmp_third", e.cmp_third, data[50:35]);
			field_diff("phase_first", e.ph_first, data[52:51]);
			field_diff("phase_second", e.ph_second, data[54:53]);
			field_diff("phase_third", e.ph_third, data[56:55]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic [15:0] s_tdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] m_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	compare_book book;
	int          cycles;
	bit          tx_steady;
	bit          rx_steady;
	int          settings_run;

	svm_compare_generator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// receiver: random stall per beat, checks every accepted beat
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			book.check_beat(m_tdata);
			@(negedge clk);
		end
	end

	// entered and left at a falling edge
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (addr == ADDR_MAG) begin
			book.magnitude = data[15:0];
		end else begin
			book.period = data[15:0];
		end
	endtask

	task automatic set_config(input logic [15:0] mag, input logic [15:0] per);
		apb_write(ADDR_MAG, {16'd0, mag});
		apb_write(ADDR_PERIOD, {16'd0, per});
		settings_run++;
	endtask

	task automatic send_angle(input logic [15:0] angle);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = angle;
		do @(posedge clk); while (!s_tready);
		book.note_angle(angle);
		@(negedge clk);
	endtask

	// sender holds off until the pipeline has delivered every beat
	task automatic drain();
		s_tvalid = 1'b0;
		while (book.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_angle();
		int          s;
		logic [15:0] a;
		case ($urandom_range(0, 9))
			7: begin
				// around a sector edge
				s = $urandom_range(0, 5);
				a = 16'((s * 65536 + 5) / 6 + $urandom_range(0, 4) - 2);
			end
			8: a = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			default: a = 16'($urandom_range(0, 65535));
		endcase
		return a;
	endfunction

	task automatic random_run(input int count);
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			send_angle(pick_angle());
		end
		drain();
	endtask

	initial begin
		logic [15:0] edge_angles [$];
		logic [15:0] mag;
		logic [15:0] per;
		book = new();
		settings_run = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		arst_n = 1'b0;
		s_tdata = '0;
		s_tvalid = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values: zero magnitude, full period
		random_run(10);

		// full magnitude over sector edges and in-sector extremes
		set_config(MAG_ONE, 16'd65535);
		edge_angles = '{16'd0, 16'd65535, 16'd10922, 16'd10923, 16'd21845, 16'd21846,
			16'd32767, 16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614,
			16'h5555, 16'haaaa, 16'd5461, 16'd43, 16'd10880, 16'd16384, 16'd49152,
			16'd1, 16'd60000};
		tx_steady = 1'b1;
		rx_steady = 1'b0;
		foreach (edge_angles[i]) begin
			send_angle(edge_angles[i]);
		end
		drain();

		// magnitude above one saturates
		set_config(16'd65535, 16'd65535);
		random_run(100);
		set_config(16'd32769, 16'd0);
		random_run(60);
		set_config(MAG_ONE, 16'd1);
		random_run(60);
		set_config(16'd16384, 16'd1000);
		random_run(40);

		for (int r = 0; r < 7; r++) begin
			case ($urandom_range(0, 5))
				0: mag = MAG_ONE;
				1: mag = 16'($urandom_range(32769, 65535));
				2: mag = 16'd0;
				default: mag = 16'($urandom_range(0, 32768));
			endcase
			case ($urandom_range(0, 3))
				0: per = 16'd65535;
				1: per = 16'($urandom_range(0, 15));
				default: per = 16'($urandom_range(0, 65535));
			endcase
			set_config(mag, per);
			random_run(90);
		end

		$display("%0d angles over %0d register settings, %0d output beats checked",
			book.angles_seen, settings_run + 1, book.beats_seen);
		$display("mismatches: %0d", book.errors);
		if (book.errors == 0 && book.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
